/* hw/rtl/lpsc_pkg.sv */
// ----------------------------------------------------------------------------
// lpsc_pkg: shared types and constants of the length prefix rewriter
// Holds the parse phase encoding, the start code and the burst record that
// the front end hands to the output serializer through the queue.
// ----------------------------------------------------------------------------
`default_nettype none

package lpsc_pkg;

  // width of a unit length prefix in bytes
  localparam int PREFIX_BYTES = 4;

  // start code 00 00 00 01, byte 0 in the lowest lane
  localparam logic [31:0] START_CODE = 32'h0100_0000;

  // byte offset saturates here
  localparam logic [23:0] OFFSET_MAX = 24'hFF_FFFF;

  // parse phase, one-hot
  typedef enum logic [3:0] {
    PH_HEADER  = 4'b0001,
    PH_COLLECT = 4'b0010,
    PH_BODY    = 4'b0100,
    PH_PASS    = 4'b1000
  } phase_t;

  // one to four output bytes caused by a single input byte
  typedef struct packed {
    logic [3:0][7:0] data;        // lane 0 goes out first
    logic [1:0]      cnt_m1;      // number of bytes minus one
    logic            failed;      // conversion failed flag for all bytes
    logic            sample_end;  // last byte of the burst ends the sample
  } burst_t;

endpackage

`default_nettype wire

/* hw/rtl/lpsc_front.sv */
// ----------------------------------------------------------------------------
// lpsc_front: header parser
// Tracks unit boundaries, holds header bytes and turns each input byte into
// a burst of zero to four output bytes for the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module lpsc_front
  import lpsc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        accept,
  input  wire logic [7:0]  data_byte,
  input  wire logic [23:0] sample_size,
  input  wire logic        sample_end,
  output logic             push,
  output burst_t           burst
);

  phase_t      phase, phase_next;
  logic [23:0] byte_offset, byte_offset_next;
  logic [1:0]  header_count, header_count_next;
  logic [23:0] body_remaining, body_remaining_next;
  logic        failed_flag, failed_flag_next;
  logic [7:0]  held_header [3];
  logic [7:0]  held_header_next [3];

  logic        emit;
  logic [31:0] unit_len;
  logic [24:0] header_end;
  logic [23:0] body_dec;

  assign unit_len   = {held_header[0], held_header[1], held_header[2], data_byte};
  assign header_end = {1'b0, byte_offset} + 25'(PREFIX_BYTES);
  assign body_dec   = (body_remaining != 24'd0) ? body_remaining - 24'd1 : body_remaining;

  // next state and burst for the current byte
  always_comb begin
    phase_next          = phase;
    header_count_next   = header_count;
    body_remaining_next = body_remaining;
    failed_flag_next    = failed_flag;
    held_header_next    = held_header;
    emit                = 1'b0;
    burst.data          = {4{data_byte}};
    burst.cnt_m1        = 2'd0;
    burst.sample_end    = sample_end;

    case (phase)
      PH_HEADER: begin
        if (header_end < {1'b0, sample_size}) begin
          held_header_next[0] = data_byte;
          header_count_next   = 2'd1;
          phase_next          = PH_COLLECT;
        end else begin
          emit       = 1'b1;
          phase_next = PH_PASS;
        end
      end
      PH_COLLECT: begin
        if (header_count != 2'd3) begin
          held_header_next[header_count] = data_byte;
          header_count_next              = header_count + 2'd1;
        end else begin
          header_count_next = 2'd0;
          emit              = 1'b1;
          burst.cnt_m1      = 2'd3;
          if (unit_len > {8'h00, sample_size}) begin
            // length overruns the sample: release header unchanged
            failed_flag_next = 1'b1;
            burst.data       = {data_byte, held_header[2], held_header[1], held_header[0]};
            phase_next       = PH_PASS;
          end else begin
            burst.data          = START_CODE;
            body_remaining_next = unit_len[23:0];
            phase_next          = (unit_len[23:0] != 24'd0) ? PH_BODY : PH_HEADER;
          end
        end
      end
      PH_BODY: begin
        emit                = 1'b1;
        body_remaining_next = body_dec;
        if (body_dec == 24'd0) begin
          phase_next = PH_HEADER;
        end
      end
      default: begin
        emit = 1'b1;
      end
    endcase

    byte_offset_next = (byte_offset != OFFSET_MAX) ? byte_offset + 24'd1 : byte_offset;
    burst.failed     = failed_flag_next;

    // sample ends inside a header: held bytes, then the current byte
    if (sample_end && !emit) begin
      for (int i = 0; i < 3; i++) begin
        burst.data[i] = (2'(i) < header_count_next) ? held_header_next[i] : data_byte;
      end
      burst.data[3] = data_byte;
      burst.cnt_m1  = header_count_next;
    end

    // end of sample returns everything to the start
    if (sample_end) begin
      phase_next          = PH_HEADER;
      byte_offset_next    = 24'd0;
      header_count_next   = 2'd0;
      body_remaining_next = 24'd0;
      failed_flag_next    = 1'b0;
    end
  end

  assign push = accept && (emit || sample_end);

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_HEADER;
      byte_offset    <= 24'd0;
      header_count   <= 2'd0;
      body_remaining <= 24'd0;
      failed_flag    <= 1'b0;
    end else if (accept) begin
      phase          <= phase_next;
      byte_offset    <= byte_offset_next;
      header_count   <= header_count_next;
      body_remaining <= body_remaining_next;
      failed_flag    <= failed_flag_next;
    end
  end

  // held header bytes
  always_ff @(posedge clk) begin
    if (accept) begin
      held_header <= held_header_next;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/lpsc_fifo.sv */
// ----------------------------------------------------------------------------
// lpsc_fifo: burst queue
// Small register queue between the parser and the serializer so that each
// side stalls on its own.
// ----------------------------------------------------------------------------
`default_nettype none

module lpsc_fifo
  import lpsc_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   push,
  input  wire burst_t push_burst,
  input  wire logic   pop,
  output burst_t      head,
  output logic        empty,
  output logic        full
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  burst_t          entries [DEPTH];
  logic [AW-1:0]   wr_ptr, rd_ptr;
  logic [CW-1:0]   count;

  assign empty = (count == CW'(0));
  assign full  = (count == CW'(DEPTH));
  assign head  = entries[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_burst;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/lpsc_back.sv */
// ----------------------------------------------------------------------------
// lpsc_back: output serializer
// Sends the bytes of the burst at the head of the queue one per transfer and
// marks the last byte of each burst and of each sample.
// ----------------------------------------------------------------------------
`default_nettype none

module lpsc_back
  import lpsc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire burst_t      head,
  input  wire logic        empty,
  output logic             pop,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [7:0]       m_tdata,
  output logic             m_tlast,
  output logic [1:0]       m_tuser
);

  logic [1:0] beat;
  logic       last_beat;

  assign last_beat = (beat == head.cnt_m1);
  assign m_tvalid  = !empty;
  assign m_tdata   = head.data[beat];
  assign m_tlast   = head.sample_end && last_beat;
  assign m_tuser   = {last_beat, head.failed};
  assign pop       = m_tvalid && m_tready && last_beat;

  // byte position inside the current burst
  always_ff @(posedge clk) begin
    if (rst) begin
      beat <= 2'd0;
    end else if (m_tvalid && m_tready) begin
      beat <= last_beat ? 2'd0 : beat + 2'd1;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/length_prefix_to_start_code_core.sv */
// ----------------------------------------------------------------------------
// length_prefix_to_start_code_core: length prefix to start code rewriter
// Rewrites each 4-byte big-endian unit length of a video sample as the start
// code 00 00 00 01; overrunning lengths pass through flagged as failed.
//
//   channel  dir  signals                       content
//   s_*      in   tvalid tready tdata tlast     sample bytes in order
//   m_*      out  tvalid tready tdata tlast     rewritten bytes
//                 tuser
//
// One input byte is taken per cycle unless the queue is full, and one output
// byte leaves per cycle while m_tready is high. A header byte is held, the
// fourth releases four bytes; a sample ending inside a header releases up
// to four bytes from one input. The serializer at one byte per cycle sets
// the output rate, and QUEUE_DEPTH bursts absorb header releases. Reset is
// synchronous, no clearing. Input stalls only when the queue is full.
// ----------------------------------------------------------------------------
`default_nettype none

module length_prefix_to_start_code_core
  import lpsc_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // data_byte [7:0], sample_size [31:8]
  input  wire logic        s_tlast,   // sample_end
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [7:0]       m_tdata,   // out_byte [7:0]
  output logic             m_tlast,   // out_sample_end
  output logic [1:0]       m_tuser    // convert_failed [0], run_last [1]
);

  logic   accept;
  logic   push, pop, empty, full;
  burst_t push_burst, head;

  // input transfer
  assign s_tready = !full;
  assign accept   = s_tvalid && s_tready;

  lpsc_front u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .data_byte   (s_tdata[7:0]),
    .sample_size (s_tdata[31:8]),
    .sample_end  (s_tlast),
    .push        (push),
    .burst       (push_burst)
  );

  lpsc_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_burst (push_burst),
    .pop        (pop),
    .head       (head),
    .empty      (empty),
    .full       (full)
  );

  lpsc_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .empty    (empty),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

endmodule

`default_nettype wire

/* verif/lpsc_rewrite_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lpsc_rewrite_checker: scoreboard of the length prefix rewriter
// Watches both stream channels, rewrites every accepted sample byte with its
// own copy of the parse state and compares each output transfer, field by
// field, with the oldest predicted byte. Hands its counts to the test top.
// ----------------------------------------------------------------------------
module lpsc_rewrite_checker
  import lpsc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  input  wire logic        s_tready,
  input  wire logic [31:0] s_tdata,   // data_byte [7:0], sample_size [31:8]
  input  wire logic        s_tlast,   // sample_end
  input  wire logic        m_tvalid,
  input  wire logic        m_tready,
  input  wire logic [7:0]  m_tdata,   // out_byte [7:0]
  input  wire logic        m_tlast,   // out_sample_end
  input  wire logic [1:0]  m_tuser,   // convert_failed [0], run_last [1]
  output int               mismatches,
  output int               pending
);

  typedef struct packed {
    logic [7:0] data;
    logic       sample_end;
    logic       failed;
    logic       run_last;
  } out_byte_t;

  // predicted output bytes, oldest first
  out_byte_t rewritten_q[$];

  // bytes caused by the current input byte
  out_byte_t staged[4];
  int        stage_n;

  // parse state of the current sample
  logic [23:0] offset;
  phase_t      parse_ph;
  logic [1:0]  held_cnt;
  logic [31:0] len_acc;
  logic [7:0]  held[3];
  logic [23:0] body_left;
  logic        fail_seen;

  initial mismatches = 0;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch at %0t: %s got %0h, want %0h", $time, what, got, want);
    mismatches = mismatches + 1;
  endtask

  task automatic restart_sample();
    offset    = '0;
    parse_ph  = PH_HEADER;
    held_cnt  = '0;
    len_acc   = '0;
    held[0]   = '0;
    held[1]   = '0;
    held[2]   = '0;
    body_left = '0;
    fail_seen = 1'b0;
  endtask

  function automatic void stage_byte(input logic [7:0] b);
    staged[stage_n] = '{b, 1'b0, fail_seen, 1'b0};
    stage_n++;
  endfunction

  // one sample byte in, zero to four rewritten bytes queued
  task automatic rewrite_byte(input logic [7:0] b, input logic [23:0] size, input logic last);
    logic [31:0] len;
    stage_n = 0;
    case (parse_ph)
      PH_HEADER: begin
        if (32'(offset) + 32'(PREFIX_BYTES) < 32'(size)) begin
          held[0]  = b;
          len_acc  = 32'(b);
          held_cnt = 2'd1;
          parse_ph = PH_COLLECT;
        end else begin
          parse_ph = PH_PASS;
          stage_byte(b);
        end
      end
      PH_COLLECT: begin
        if (int'(held_cnt) < PREFIX_BYTES - 1) begin
          held[held_cnt] = b;
          len_acc        = {len_acc[23:0], b};
          held_cnt       = held_cnt + 2'd1;
        end else begin
          len      = {len_acc[23:0], b};
          held_cnt = '0;
          len_acc  = '0;
          if (len > 32'(size)) begin
            // overrunning length: original header goes out flagged
            fail_seen = 1'b1;
            for (int i = 0; i < PREFIX_BYTES - 1; i++) stage_byte(held[i]);
            stage_byte(b);
            parse_ph = PH_PASS;
          end else begin
            for (int i = 0; i < PREFIX_BYTES; i++) stage_byte(START_CODE[8*i +: 8]);
            body_left = len[23:0];
            parse_ph  = (body_left != '0) ? PH_BODY : PH_HEADER;
          end
        end
      end
      PH_BODY: begin
        stage_byte(b);
        if (body_left != '0) body_left = body_left - 24'd1;
        if (body_left == '0) parse_ph = PH_HEADER;
      end
      default: stage_byte(b);
    endcase

    if (offset != OFFSET_MAX) offset = offset + 24'd1;

    if (last) begin
      // sample ended inside a header: held bytes go out as they came
      if (stage_n == 0) begin
        for (int i = 0; i < int'(held_cnt) && i < 3; i++) stage_byte(held[i]);
        stage_byte(b);
      end
      staged[stage_n-1].sample_end = 1'b1;
    end
    if (stage_n > 0) staged[stage_n-1].run_last = 1'b1;

    for (int i = 0; i < stage_n; i++) rewritten_q.push_back(staged[i]);
    if (last) restart_sample();
  endtask

  // watch both channels on the rising edge
  always @(posedge clk) begin
    out_byte_t want;
    if (rst) begin
      restart_sample();
      rewritten_q.delete();
      pending <= 0;
    end else begin
      if (s_tvalid && s_tready) rewrite_byte(s_tdata[7:0], s_tdata[31:8], s_tlast);
      if (m_tvalid && m_tready) begin
        if (rewritten_q.size() == 0) begin
          report("output transfer with nothing predicted, out_byte", 32'(m_tdata), 32'd0);
        end else begin
          want = rewritten_q.pop_front();
          if (m_tdata !== want.data) report("out_byte", 32'(m_tdata), 32'(want.data));
          if (m_tlast !== want.sample_end)
            report("out_sample_end", 32'(m_tlast), 32'(want.sample_end));
          if (m_tuser[0] !== want.failed)
            report("convert_failed", 32'(m_tuser[0]), 32'(want.failed));
          if (m_tuser[1] !== want.run_last)
            report("run_last", 32'(m_tuser[1]), 32'(want.run_last));
        end
      end
      pending <= rewritten_q.size();
    end
  end

endmodule

/* verif/length_prefix_to_start_code_core_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// length_prefix_to_start_code_core_test: test top of the prefix rewriter
// Sends directed samples and then random well-formed, overrunning, broken and
// noise samples under changing idle and stall patterns, with one long output
// hold-off and two drain pauses. The checker judges every output transfer.
// ----------------------------------------------------------------------------
module length_prefix_to_start_code_core_test;
  import lpsc_pkg::*;

  localparam int DIRECTED_ITEMS  = 24;
  localparam int RANDOM_ITEMS    = 146;
  localparam int HOLD_OFF_CYCLES = 150;
  localparam int MAX_GAP         = 20;
  localparam int STALL_LIMIT     = 2000;
  localparam int DRAIN_CYCLES    = 16;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic [31:0] s_tdata  = '0;   // data_byte [7:0], sample_size [31:8]
  logic        s_tlast  = 1'b0; // sample_end
  logic        m_tready = 1'b0;
  wire logic       s_tready;
  wire logic       m_tvalid;
  wire logic [7:0] m_tdata;    // out_byte [7:0]
  wire logic       m_tlast;    // out_sample_end
  wire logic [1:0] m_tuser;    // convert_failed [0], run_last [1]

  int mismatches;
  int pending;

  // idling controls of the sender and the receiver
  int send_idle_pct = 0;
  int stall_pct     = 0;
  bit hold_req      = 1'b0;

  int         bytes_sent = 0;
  int         idle_cycles = 0;
  logic [7:0] frame_bytes[$];

  always #6 clk = ~clk;

  length_prefix_to_start_code_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  lpsc_rewrite_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tlast    (s_tlast),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast),
    .m_tuser    (m_tuser),
    .mismatches (mismatches),
    .pending    (pending)
  );

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // receiver: random stalls, or one long hold-off on request
  initial begin
    @(negedge clk);
    forever begin
      if (hold_req) begin
        for (int c = 0; c < HOLD_OFF_CYCLES; c++) begin
          m_tready <= 1'b0;
          @(negedge clk);
        end
        hold_req = 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= stall_pct);
        @(negedge clk);
      end
    end
  end

  task automatic set_idling(input int mode);
    case (mode)
      0: begin send_idle_pct = 0;  stall_pct = 0;  end
      1: begin send_idle_pct = 54; stall_pct = 0;  end
      2: begin send_idle_pct = 0;  stall_pct = 54; end
      default: begin send_idle_pct = 34; stall_pct = 34; end
    endcase
  endtask

  // one byte transfer on the input, entered and left at a falling edge
  task automatic push_byte(input logic [7:0] b, input logic [23:0] size, input logic last);
    int gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
      gap++;
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {size, b};
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
    bytes_sent++;
  endtask

  // whole sample, sample_end on its final byte; wobble varies the size per byte
  task automatic send_frame(input logic [23:0] size, input bit wobble);
    logic [23:0] sz;
    for (int i = 0; i < frame_bytes.size(); i++) begin
      sz = (wobble && $urandom_range(3) == 0) ? 24'($urandom) : size;
      push_byte(frame_bytes[i], sz, i == frame_bytes.size() - 1);
    end
  endtask

  // chain of well-formed units with random bodies
  task automatic build_units(input int units, input int max_len);
    logic [31:0] len;
    frame_bytes.delete();
    for (int u = 0; u < units; u++) begin
      len = 32'($urandom_range(max_len));
      for (int k = 3; k >= 0; k--) frame_bytes.push_back(len[8*k +: 8]);
      for (int k = 0; k < int'(len); k++) frame_bytes.push_back(8'($urandom));
    end
  endtask

  // sender stops and waits until every predicted byte is out
  task automatic drain_pause();
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  initial begin
    int          pick;
    int          fsize;
    int          keep;
    logic [31:0] len;
    bit          hold_done;
    hold_done = 1'b0;

    repeat (4) @(negedge clk);
    rst <= 1'b0;
    set_idling(0);

    // one unit converted, body of extreme bytes
    frame_bytes = '{8'h00, 8'h00, 8'h00, 8'h02, 8'hFF, 8'h00};
    send_frame(24'd6, 1'b0);
    // overrunning length passes through flagged
    frame_bytes = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h5A};
    send_frame(24'd5, 1'b0);
    // sample end inside a header, largest sample size
    frame_bytes = '{8'h00, 8'h00, 8'hFF};
    send_frame(24'hFF_FFFF, 1'b0);
    // zero length unit followed by another header
    frame_bytes = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'hAA};
    send_frame(24'd9, 1'b0);
    // zero sample size, plain pass-through
    frame_bytes = '{8'hFF};
    send_frame(24'd0, 1'b0);

    drain_pause();

    while (bytes_sent < DIRECTED_ITEMS + RANDOM_ITEMS) begin
      set_idling((bytes_sent / 40) % 4);
      if (!hold_done && bytes_sent > 110) begin
        hold_req  = 1'b1;
        hold_done = 1'b1;
      end
      pick = $urandom_range(99);
      if (pick < 60) begin
        // well-formed sample, sometimes with a size off or cut short
        build_units($urandom_range(1, 3), ($urandom_range(9) == 0) ? 40 : 6);
        fsize = frame_bytes.size();
        if ($urandom_range(4) == 0) fsize = fsize + $urandom_range(8);
        else if ($urandom_range(4) == 0) fsize = fsize - $urandom_range(3);
        if (fsize < 0) fsize = 0;
        if ($urandom_range(5) == 0) begin
          keep = $urandom_range(1, frame_bytes.size());
          while (frame_bytes.size() > keep) void'(frame_bytes.pop_back());
        end
        send_frame(24'(fsize), 1'b0);
      end else if (pick < 75) begin
        // overrunning length, possibly after a good unit
        build_units($urandom_range(1), 2);
        fsize = frame_bytes.size() + 5 + $urandom_range(6);
        len = $urandom;
        if (len <= 32'(fsize)) len = 32'(fsize) + 1 + $urandom_range(255);
        for (int k = 3; k >= 0; k--) frame_bytes.push_back(len[8*k +: 8]);
        while (frame_bytes.size() < fsize) frame_bytes.push_back(8'($urandom));
        send_frame(24'(fsize), 1'b0);
      end else begin
        // noise: random bytes and sizes, size changing within the sample
        frame_bytes.delete();
        keep = $urandom_range(1, 8);
        for (int k = 0; k < keep; k++) frame_bytes.push_back(8'($urandom));
        fsize = $urandom_range(1) ? $urandom_range(16) : int'($urandom & 32'h00FF_FFFF);
        send_frame(24'(fsize), 1'b1);
      end
    end

    drain_pause();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
